// File: sv/sdf_pkg.sv
// sdf_pkg: shared constants and types for the stream duplicate filter
// no dependencies; used by the interfaces, the comparator cell and the top level

package sdf_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // control flags that travel with each beat along the cell chain
    typedef struct packed {
        logic vld;
        logic last;
        logic dup;
        logic stored;
    } t_flags;

endpackage

// File: sv/sdf_in_if.sv
// sdf_in_if: input stream channel of the duplicate filter (valid/ready, value, last)
// depends on sdf_pkg for the default value width

interface sdf_in_if #(
    parameter int VALUE_WIDTH = sdf_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

// File: sv/sdf_out_if.sv
// sdf_out_if: result stream channel of the duplicate filter
// depends on sdf_pkg for the default value width

interface sdf_out_if #(
    parameter int VALUE_WIDTH = sdf_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic                          is_duplicate;
    logic                          out_last;
    logic                          overflow;

    modport source (output valid, output out_value, output is_duplicate,
                    output out_last, output overflow, input ready);
    modport sink (input valid, input out_value, input is_duplicate,
                  input out_last, input overflow, output ready);
endinterface

// File: sv/sdf_cell.sv
// sdf_cell: one comparator cell of the chain, holds one table entry and one beat stage
// depends on sdf_pkg (t_flags)

module sdf_cell #(
    parameter int VALUE_WIDTH = sdf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  sdf_pkg::t_flags        i_flags,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output sdf_pkg::t_flags        o_flags,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_full
);

    sdf_pkg::t_flags        r_flags;
    sdf_pkg::t_flags        n_flags;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_entry;
    logic [VALUE_WIDTH-1:0] n_entry;
    logic                   r_full;
    logic                   n_full;
    logic                   w_match;
    logic                   w_take;

    always_comb begin
        w_match = r_full && (r_entry == i_value);
        w_take  = i_flags.vld && !r_full && !i_flags.dup && !i_flags.stored;

        n_flags        = i_flags;
        n_flags.dup    = i_flags.dup | (i_flags.vld & w_match);
        n_flags.stored = i_flags.stored | w_take;

        n_full  = r_full;
        n_entry = r_entry;
        if (w_take) begin
            n_full  = 1'b1;
            n_entry = i_value;
        end
        // end of list empties the entry once the beat has passed
        if (i_flags.vld && i_flags.last) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_full  <= 1'b0;
        end else if (i_en) begin
            r_flags <= n_flags;
            r_full  <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_value;
            r_entry <= n_entry;
        end
    end

    assign o_flags = r_flags;
    assign o_value = r_value;
    assign o_full  = r_full;

endmodule

// File: sv/stream_duplicate_filter.sv
// stream_duplicate_filter: order-preserving duplicate marking over a chain of comparator cells
// depends on sdf_pkg, sdf_in_if, sdf_out_if and sdf_cell
//
//   port     dir   contents
//   i_in     in    value, last
//   o_out    out   out_value, is_duplicate, out_last, overflow
//
// one beat enters per cycle while o_out is not stalled; each result leaves after its beat has
// passed the chain of TABLE_DEPTH registered cells, one cell per table entry
// a stall on o_out freezes the whole chain; i_in.ready follows the chain enable
// synchronous active-low reset empties the table and drops all beats in flight

module stream_duplicate_filter #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = sdf_pkg::VALUE_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sdf_in_if.sink   i_in,
    sdf_out_if.source o_out
);

    sdf_pkg::t_flags        w_flags [TABLE_DEPTH+1];
    logic [VALUE_WIDTH-1:0] w_value [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_full;
    logic                   w_adv;

    assign w_adv = !w_flags[TABLE_DEPTH].vld || o_out.ready;

    always_comb begin
        w_flags[0]        = '0;
        w_flags[0].vld    = i_in.valid;
        w_flags[0].last   = i_in.last;
        w_value[0]        = i_in.value;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        sdf_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_flags (w_flags[g]),
            .i_value (w_value[g]),
            .o_flags (w_flags[g+1]),
            .o_value (w_value[g+1]),
            .o_full  (w_full[g])
        );
    end

    assign i_in.ready         = w_adv;
    assign o_out.valid        = w_flags[TABLE_DEPTH].vld;
    assign o_out.out_value    = w_value[TABLE_DEPTH];
    assign o_out.is_duplicate = w_flags[TABLE_DEPTH].dup;
    assign o_out.out_last     = w_flags[TABLE_DEPTH].last;
    assign o_out.overflow     = !w_flags[TABLE_DEPTH].dup && !w_flags[TABLE_DEPTH].stored;

`ifndef SYNTH
    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_flags[TABLE_DEPTH]) && $stable(w_value[TABLE_DEPTH]))
        else $error("result stage changed during stall");

    a_last_empties_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && i_in.valid && i_in.last) |=> !w_full[0])
        else $error("head entry still held after end of list");

    a_new_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && i_in.valid && !i_in.last && !w_full[0]) |=> w_full[0])
        else $error("first beat of list not stored in head entry");
`endif

endmodule
